### design/cppr_pkg.sv
// Shared types, widths and codes of the code point page/range lookup.
package cppr_pkg;

    localparam int CP_W       = 21;
    localparam int SLOT_W     = 12;
    localparam int KEY_W      = 13;
    localparam int LEN_W      = 9;
    localparam int BASE_W     = 12;
    localparam int PIU_W      = 9;
    localparam int PAGE_SHIFT = 8;

    localparam int PAGE_DEPTH  = 256;
    localparam int RANGE_DEPTH = 1024;
    localparam int ENTRY_DEPTH = 4096;
    localparam int PAGE_AW     = $clog2(PAGE_DEPTH);
    localparam int RANGE_AW    = $clog2(RANGE_DEPTH);
    localparam int ENTRY_AW    = $clog2(ENTRY_DEPTH);

    // search window offsets (lo, hi, mid) never exceed a 9-bit count
    localparam int OFS_W = LEN_W;

    typedef enum logic [1:0] {
        KIND_LOAD_PAGE  = 2'd0,
        KIND_LOAD_RANGE = 2'd1,
        KIND_LOAD_ENTRY = 2'd2,
        KIND_LOOKUP     = 2'd3
    } t_kind;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [RANGE_AW-1:0] rbase;
        logic [LEN_W-1:0]    rcount;
    } t_page;

    typedef struct packed {
        logic [CP_W-1:0]   first;
        logic [LEN_W-1:0]  len;
        logic [BASE_W-1:0] ebase;
    } t_range;

    // controller -> datapath
    typedef struct packed {
        logic wr_page;
        logic wr_range;
        logic wr_entry;
        logic pg_init;
        logic pg_step;
        logic rg_init;
        logic rg_step;
        logic en_read;
        logic fin_miss;
        logic fin_entry;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic pg_lt;
        logic pg_gt;
        logic rg_lt;
        logic rg_ge;
    } t_status;

endpackage

### design/cppr_dp.sv
// Datapath: table memories, shared halving-search window, entry check and result regs.
module cppr_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cppr_pkg::t_cmd                     i_cmd,
    output cppr_pkg::t_status                  o_status,
    input  logic                               i_cfg_we,
    input  logic [cppr_pkg::PIU_W-1:0]         i_cfg_wdata,
    input  logic [cppr_pkg::SLOT_W-1:0]        i_slot,
    input  logic [cppr_pkg::CP_W-1:0]          i_code_point,
    input  logic [cppr_pkg::KEY_W-1:0]         i_page_key,
    input  logic [cppr_pkg::LEN_W-1:0]         i_length,
    input  logic [cppr_pkg::BASE_W-1:0]        i_base,
    input  logic                               i_has_candidates,
    output logic                               o_found,
    output logic [cppr_pkg::ENTRY_AW-1:0]      o_entry_index
);

    logic [cppr_pkg::PIU_W-1:0]    r_pages_in_use;

    cppr_pkg::t_page               r_pg_mem [cppr_pkg::PAGE_DEPTH];
    cppr_pkg::t_page               r_pg_q;
    cppr_pkg::t_range              r_rg_mem [cppr_pkg::RANGE_DEPTH];
    cppr_pkg::t_range              r_rg_q;
    logic                          r_en_mem [cppr_pkg::ENTRY_DEPTH];
    logic                          r_en_q;

    logic [cppr_pkg::CP_W-1:0]     r_cp;
    logic [cppr_pkg::OFS_W-1:0]    r_lo, r_hi, r_mid;
    logic [cppr_pkg::OFS_W-1:0]    n_lo, n_hi, n_mid;
    logic [cppr_pkg::OFS_W:0]      n_sum;
    logic [cppr_pkg::RANGE_AW-1:0] r_first;
    logic [cppr_pkg::ENTRY_AW-1:0] r_entry;
    logic                          r_entry_oor;
    logic                          r_found;
    logic [cppr_pkg::ENTRY_AW-1:0] r_entry_index;

    logic [cppr_pkg::KEY_W-1:0]    key_probe;
    logic [cppr_pkg::OFS_W-1:0]    pg_hi_init, rg_hi_init;
    logic [cppr_pkg::RANGE_AW:0]   rg_avail;
    logic [cppr_pkg::CP_W:0]       rg_end;
    logic [cppr_pkg::CP_W-1:0]     cp_off;
    logic [cppr_pkg::ENTRY_AW:0]   entry_sum;
    logic [cppr_pkg::RANGE_AW-1:0] rg_base;
    logic [cppr_pkg::RANGE_AW:0]   rg_addr_sum;
    logic [cppr_pkg::PAGE_AW-1:0]  pg_addr;
    logic [cppr_pkg::RANGE_AW-1:0] rg_addr;
    logic                          hit_valid;

    // ---- compares on the registered probe data ----
    assign key_probe = r_cp[cppr_pkg::CP_W-1:cppr_pkg::PAGE_SHIFT];
    assign rg_end    = {1'b0, r_rg_q.first} + (cppr_pkg::CP_W+1)'(r_rg_q.len);
    assign cp_off    = r_cp - r_rg_q.first;
    // offset is below the range length on a hit, so 9 bits carry it
    assign entry_sum = {1'b0, r_rg_q.ebase}
                     + (cppr_pkg::ENTRY_AW+1)'(cp_off[cppr_pkg::LEN_W-1:0]);

    assign o_status.empty = (r_lo >= r_hi);
    assign o_status.pg_lt = (key_probe < r_pg_q.key);
    assign o_status.pg_gt = (key_probe > r_pg_q.key);
    assign o_status.rg_lt = (r_cp < r_rg_q.first);
    assign o_status.rg_ge = ({1'b0, r_cp} >= rg_end);

    // page count saturates at the table depth
    assign pg_hi_init = (r_pages_in_use > cppr_pkg::PIU_W'(cppr_pkg::PAGE_DEPTH))
                      ? cppr_pkg::PIU_W'(cppr_pkg::PAGE_DEPTH) : r_pages_in_use;

    // range count clipped so the page's ranges stay inside the table
    assign rg_avail   = (cppr_pkg::RANGE_AW+1)'(cppr_pkg::RANGE_DEPTH) - {1'b0, r_pg_q.rbase};
    assign rg_hi_init = ((cppr_pkg::RANGE_AW+1)'(r_pg_q.rcount) > rg_avail)
                      ? rg_avail[cppr_pkg::OFS_W-1:0] : r_pg_q.rcount;

    // ---- window update ----
    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (i_cmd.pg_init) begin
            n_lo = '0;
            n_hi = pg_hi_init;
        end else if (i_cmd.rg_init) begin
            n_lo = '0;
            n_hi = rg_hi_init;
        end else if (i_cmd.pg_step) begin
            if (o_status.pg_lt) begin
                n_hi = r_mid;
            end else begin
                n_lo = r_mid + cppr_pkg::OFS_W'(1);
            end
        end else if (i_cmd.rg_step) begin
            if (o_status.rg_lt) begin
                n_hi = r_mid;
            end else begin
                n_lo = r_mid + cppr_pkg::OFS_W'(1);
            end
        end
    end

    assign n_sum       = {1'b0, n_lo} + {1'b0, n_hi};
    assign n_mid       = n_sum[cppr_pkg::OFS_W:1];
    assign pg_addr     = n_mid[cppr_pkg::PAGE_AW-1:0];
    assign rg_base     = i_cmd.rg_init ? r_pg_q.rbase : r_first;
    assign rg_addr_sum = {1'b0, rg_base} + (cppr_pkg::RANGE_AW+1)'(n_mid);
    assign rg_addr     = rg_addr_sum[cppr_pkg::RANGE_AW-1:0];

    // ---- page count register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pages_in_use <= '0;
        end else if (i_cfg_we) begin
            r_pages_in_use <= i_cfg_wdata;
        end
    end

    // ---- memories ----
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_page && (i_slot < cppr_pkg::SLOT_W'(cppr_pkg::PAGE_DEPTH))) begin
            r_pg_mem[i_slot[cppr_pkg::PAGE_AW-1:0]] <=
                {i_page_key, i_base[cppr_pkg::RANGE_AW-1:0], i_length};
        end
        if (i_cmd.pg_init || i_cmd.pg_step) begin
            r_pg_q <= r_pg_mem[pg_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_range && (i_slot < cppr_pkg::SLOT_W'(cppr_pkg::RANGE_DEPTH))) begin
            r_rg_mem[i_slot[cppr_pkg::RANGE_AW-1:0]] <= {i_code_point, i_length, i_base};
        end
        if (i_cmd.rg_init || i_cmd.rg_step) begin
            r_rg_q <= r_rg_mem[rg_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry) begin
            r_en_mem[i_slot[cppr_pkg::ENTRY_AW-1:0]] <= i_has_candidates;
        end
        if (i_cmd.en_read) begin
            r_en_q <= r_en_mem[entry_sum[cppr_pkg::ENTRY_AW-1:0]];
        end
    end

    // ---- search and result registers ----
    assign hit_valid = r_en_q && !r_entry_oor;

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        if (i_cmd.pg_init) begin
            r_cp <= i_code_point;
        end
        if (i_cmd.rg_init) begin
            r_first <= r_pg_q.rbase;
        end
        if (i_cmd.en_read) begin
            r_entry     <= entry_sum[cppr_pkg::ENTRY_AW-1:0];
            r_entry_oor <= entry_sum[cppr_pkg::ENTRY_AW];
        end
        if (i_cmd.fin_miss) begin
            r_found       <= 1'b0;
            r_entry_index <= '0;
        end else if (i_cmd.fin_entry) begin
            r_found       <= hit_valid;
            r_entry_index <= hit_valid ? r_entry : '0;
        end
    end

    assign o_found       = r_found;
    assign o_entry_index = r_entry_index;

endmodule

### design/cppr_ctrl.sv
// Controller: issues table loads and sequences page search, range search and entry check.
module cppr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_kind,
    input  cppr_pkg::t_status i_status,
    output cppr_pkg::t_cmd    o_cmd,
    output logic              o_busy,
    output logic              o_valid
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAGE,
        S_RANGE,
        S_ENTRY
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;
    logic   r_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_kind)
                        cppr_pkg::KIND_LOAD_PAGE:  o_cmd.wr_page  = 1'b1;
                        cppr_pkg::KIND_LOAD_RANGE: o_cmd.wr_range = 1'b1;
                        cppr_pkg::KIND_LOAD_ENTRY: o_cmd.wr_entry = 1'b1;
                        cppr_pkg::KIND_LOOKUP: begin
                            o_cmd.pg_init = 1'b1;
                            n_state       = S_PAGE;
                        end
                        default: ;
                    endcase
                end
            end
            S_PAGE: begin
                if (i_status.empty) begin
                    o_cmd.fin_miss = 1'b1;
                    n_state        = S_IDLE;
                end else if (i_status.pg_lt || i_status.pg_gt) begin
                    o_cmd.pg_step = 1'b1;
                end else begin
                    o_cmd.rg_init = 1'b1;
                    n_state       = S_RANGE;
                end
            end
            S_RANGE: begin
                if (i_status.empty) begin
                    o_cmd.fin_miss = 1'b1;
                    n_state        = S_IDLE;
                end else if (i_status.rg_lt || i_status.rg_ge) begin
                    o_cmd.rg_step = 1'b1;
                end else begin
                    o_cmd.en_read = 1'b1;
                    n_state       = S_ENTRY;
                end
            end
            S_ENTRY: begin
                o_cmd.fin_entry = 1'b1;
                n_state         = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_valid <= o_cmd.fin_miss || o_cmd.fin_entry;
        end
    end

    assign o_busy  = r_busy;
    assign o_valid = r_valid;

endmodule

### design/code_point_page_range_lookup_core.sv
// Top level of the two-level code point page/range lookup.
//
// Usage:
//   Command channel: a word is taken at a rising edge with i_start high and
//   o_busy low. i_kind picks load page, load range, load entry or lookup.
//   Loads write one table slot at that edge and give no result; o_busy stays
//   low, so loads can stream one per cycle. Slots beyond a table are dropped.
//   A lookup raises o_busy, binary-searches the page table for the code
//   point's upper bits, then that page's ranges, then reads the entry valid
//   bit. Each search probe is one read of a registered-read memory.
//   A new word may be taken in the cycle the result is shown.
//   Result: o_valid is high for exactly one cycle with o_found and
//   o_entry_index; entry index is 0 when not found. The receiver cannot
//   stall; a result not taken in that cycle is gone.
//   Config: i_cfg_we writes pages_in_use (i_cfg_wdata) at once; write only
//   while idle. Values above 256 search all 256 page slots.
//   Reset: synchronous, active low; clears control state and pages_in_use.
//   Table contents are undefined until loaded.
module code_point_page_range_lookup_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [1:0]                    i_kind,
    input  logic [cppr_pkg::SLOT_W-1:0]   i_slot,
    input  logic [cppr_pkg::CP_W-1:0]     i_code_point,
    input  logic [cppr_pkg::KEY_W-1:0]    i_page_key,
    input  logic [cppr_pkg::LEN_W-1:0]    i_length,
    input  logic [cppr_pkg::BASE_W-1:0]   i_base,
    input  logic                          i_has_candidates,
    input  logic                          i_cfg_we,
    input  logic [cppr_pkg::PIU_W-1:0]    i_cfg_wdata,
    output logic                          o_valid,
    output logic                          o_found,
    output logic [cppr_pkg::ENTRY_AW-1:0] o_entry_index
);

    cppr_pkg::t_cmd    cmd;
    cppr_pkg::t_status status;

    // state machine: steps the search, owns busy and the result strobe
    cppr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_kind   (i_kind),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy),
        .o_valid  (o_valid)
    );

    // tables, search window and result registers
    cppr_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_slot           (i_slot),
        .i_code_point     (i_code_point),
        .i_page_key       (i_page_key),
        .i_length         (i_length),
        .i_base           (i_base),
        .i_has_candidates (i_has_candidates),
        .o_found          (o_found),
        .o_entry_index    (o_entry_index)
    );

endmodule
